// ===== hw/rtl/dic_pkg.sv =====
// Shared types and constants for the duplicate index counter.
`timescale 1ns / 1ps

package dic_pkg;

    // Stream field widths
    localparam int IN_DATA_BITS     = 16;
    localparam int POINT_INDEX_BITS = 10;
    localparam int OUT_FIELD_BITS   = 16;
    localparam int OUT_DATA_BITS    = 40;

    // Usage count codes, two bits, saturating
    localparam int USE_BITS = 2;
    localparam logic [USE_BITS-1:0] USE_NONE = 2'd0;
    localparam logic [USE_BITS-1:0] USE_ONCE = 2'd1;
    localparam logic [USE_BITS-1:0] USE_MAX  = 2'd3;

    // Set tag stored beside each usage count
    localparam int EPOCH_BITS = 8;
    typedef logic [EPOCH_BITS-1:0] epoch_t;
    localparam epoch_t EPOCH_LAST = {EPOCH_BITS{1'b1}};

    // Largest value an output field can carry
    localparam logic [OUT_FIELD_BITS-1:0] OUT_MAX = {OUT_FIELD_BITS{1'b1}};

    // Result queue depth, a power of two
    localparam int FIFO_DEPTH = 4;

    // One resolved table lookup handed to the tally stage
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [USE_BITS-1:0] prev_use;
    } tally_req_t;

    // One result request, last field in the lowest bits
    typedef struct packed {
        logic                      saturated;
        logic [OUT_FIELD_BITS-1:0] repeated_key_count;
        logic [OUT_FIELD_BITS-1:0] unique_count;
    } result_t;

endpackage

// ===== hw/rtl/duplicate_index_counter_core.sv =====
// Top level of the duplicate index counter.
`timescale 1ns / 1ps

// Counts index reuse within sets of point indices. One request is accepted per
// cycle when not stalled, and a result is offered on the output once the last
// request of a set has passed the lookup register, the tally snapshot and the
// result queue. The rate rests on the usage table, a memory with one read
// and one write per cycle: each request reads its entry at acceptance, and the
// update is written back the next cycle, with the most recent write forwarded so
// that requests for the same index can follow each other without gaps. Each entry
// carries a set tag, so the table is not swept between sets; instead, after
// reset and after every 256th set, a clearing pass writes every entry once,
// yielding the write port to that set's last update, and no request is accepted
// during the pass. Up to four results can be held when the output side stalls;
// apart from the clearing pass, input stalls only when four results are outstanding.
module duplicate_index_counter_core #(
    parameter int INDEX_BITS = 10,
    parameter int COUNT_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dic_pkg::IN_DATA_BITS-1:0]   s_tdata,  // [9:0] point_index
    input  logic                               s_tlast,  // last_of_set
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] unique_count, [31:16] repeated_key_count, [32] saturated
    output logic [dic_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    import dic_pkg::*;

    localparam int WORD_BITS = EPOCH_BITS + USE_BITS;
    localparam int USED_BITS = $clog2(FIFO_DEPTH + 1);
    localparam logic [INDEX_BITS-1:0] PTR_LAST = {INDEX_BITS{1'b1}};

    logic                    accept;
    logic [INDEX_BITS-1:0]   s_idx;

    logic                    s1_valid_reg, s1_last_reg;
    logic [INDEX_BITS-1:0]   s1_idx_reg;
    epoch_t                  s1_epoch_reg;
    epoch_t                  epoch_reg;
    logic                    clearing_reg;
    logic [INDEX_BITS-1:0]   clr_ptr_reg;
    logic                    wb_valid_reg;
    logic [INDEX_BITS-1:0]   wb_addr_reg;
    logic [WORD_BITS-1:0]    wb_data_reg;
    logic [USED_BITS-1:0]    used_reg;

    logic [WORD_BITS-1:0]    rd_data, cur_word;
    epoch_t                  cur_epoch;
    logic [USE_BITS-1:0]     cur_use, prev_use, new_use;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    logic [WORD_BITS-1:0]    mem_wdata;

    tally_req_t              req;
    logic                    res_valid;
    result_t                 res;
    result_t                 out_data;
    logic                    out_pop;

    // Request intake; indices wider than the table wrap into it.
    assign s_idx    = INDEX_BITS'({{INDEX_BITS{1'b0}}, s_tdata[POINT_INDEX_BITS-1:0]});
    assign s_tready = !clearing_reg && (used_reg < USED_BITS'(FIFO_DEPTH));
    assign accept   = s_tvalid & s_tready;
    assign out_pop  = m_tvalid & m_tready;

    dic_usage_mem #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (s_idx),
        .rd_data (rd_data)
    );

    // Resolve the usage count: forward last cycle's write, ignore stale tags.
    always_comb begin
        cur_word  = (wb_valid_reg && (wb_addr_reg == s1_idx_reg)) ? wb_data_reg : rd_data;
        cur_epoch = cur_word[WORD_BITS-1:USE_BITS];
        cur_use   = cur_word[USE_BITS-1:0];
        prev_use  = (cur_epoch == s1_epoch_reg) ? cur_use : USE_NONE;
        new_use   = (prev_use == USE_MAX) ? USE_MAX : prev_use + USE_BITS'(1);
    end

    // Write port: pipeline write-back first, clearing pass in free cycles.
    always_comb begin
        mem_we    = s1_valid_reg | clearing_reg;
        mem_waddr = s1_valid_reg ? s1_idx_reg : clr_ptr_reg;
        mem_wdata = s1_valid_reg ? {s1_epoch_reg, new_use} : {epoch_reg, USE_NONE};
    end

    // Pipeline, set tag, clearing pass, forwarding record and result credits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            epoch_reg    <= '0;
            clearing_reg <= 1'b1;
            clr_ptr_reg  <= '0;
            wb_valid_reg <= 1'b0;
            used_reg     <= '0;
        end else begin
            s1_valid_reg <= accept;
            wb_valid_reg <= mem_we;

            if (clearing_reg && !s1_valid_reg) begin
                clr_ptr_reg <= clr_ptr_reg + INDEX_BITS'(1);
                if (clr_ptr_reg == PTR_LAST) begin
                    clearing_reg <= 1'b0;
                end
            end

            if (accept && s_tlast) begin
                epoch_reg <= epoch_reg + EPOCH_BITS'(1);
                if (epoch_reg == EPOCH_LAST) begin
                    clearing_reg <= 1'b1;
                    clr_ptr_reg  <= '0;
                end
            end

            if ((accept && s_tlast) && !out_pop) begin
                used_reg <= used_reg + USED_BITS'(1);
            end else if (out_pop && !(accept && s_tlast)) begin
                used_reg <= used_reg - USED_BITS'(1);
            end
        end
    end

    // Payload registers of the lookup stage and the forwarding record.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_idx_reg   <= s_idx;
            s1_last_reg  <= s_tlast;
            s1_epoch_reg <= epoch_reg;
        end
        wb_addr_reg <= mem_waddr;
        wb_data_reg <= mem_wdata;
    end

    assign req.valid    = s1_valid_reg;
    assign req.last     = s1_last_reg;
    assign req.prev_use = prev_use;

    dic_tally #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    dic_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (out_data)
    );

    assign m_tdata = OUT_DATA_BITS'(out_data);

endmodule

// ===== hw/rtl/dic_usage_mem.sv =====
// Single-port-write, single-port-read usage table with registered read data.
`timescale 1ns / 1ps

module dic_usage_mem #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 10
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/dic_tally.sv =====
// Per-set saturating counters and final result formation.
`timescale 1ns / 1ps

module dic_tally #(
    parameter int COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dic_pkg::tally_req_t req,
    output logic                res_valid,
    output dic_pkg::result_t    res
);

    import dic_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int WIDE_BITS = (COUNT_BITS > OUT_FIELD_BITS) ? COUNT_BITS : OUT_FIELD_BITS;

    logic [COUNT_BITS-1:0] item_reg, nu_reg, rep_reg;
    logic                  ovf_reg;
    logic                  s2_valid_reg;
    logic [COUNT_BITS-1:0] s2_item_reg, s2_nu_reg, s2_rep_reg;
    logic                  s2_ovf_reg;

    logic [COUNT_BITS:0]   item_sum, nu_sum, rep_sum;
    logic [COUNT_BITS-1:0] item_next, nu_next, rep_next;
    logic                  ovf_next;
    logic [1:0]            nu_inc;
    logic                  rep_inc;

    logic [COUNT_BITS-1:0] uniq;
    logic [WIDE_BITS-1:0]  uniq_w, rep_w;
    logic                  uniq_over, rep_over;

    // Increments from the usage count seen before this item.
    always_comb begin
        nu_inc  = 2'd0;
        rep_inc = 1'b0;
        case (req.prev_use)
            USE_NONE: begin
                nu_inc = 2'd0;
            end
            USE_ONCE: begin
                nu_inc  = 2'd2;
                rep_inc = 1'b1;
            end
            default: begin
                nu_inc = 2'd1;
            end
        endcase
    end

    // Saturating adds; increments are small, so the carry marks overflow.
    always_comb begin
        item_sum  = {1'b0, item_reg} + (COUNT_BITS+1)'(1);
        nu_sum    = {1'b0, nu_reg} + (COUNT_BITS+1)'(nu_inc);
        rep_sum   = {1'b0, rep_reg} + (COUNT_BITS+1)'(rep_inc);
        item_next = item_sum[COUNT_BITS] ? COUNT_MAX : item_sum[COUNT_BITS-1:0];
        nu_next   = nu_sum[COUNT_BITS] ? COUNT_MAX : nu_sum[COUNT_BITS-1:0];
        rep_next  = rep_sum[COUNT_BITS] ? COUNT_MAX : rep_sum[COUNT_BITS-1:0];
        ovf_next  = ovf_reg | item_sum[COUNT_BITS] | nu_sum[COUNT_BITS] | rep_sum[COUNT_BITS];
    end

    // Counters run over a set; the last item snapshots them and starts afresh.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg     <= '0;
            nu_reg       <= '0;
            rep_reg      <= '0;
            ovf_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= req.valid & req.last;
            if (req.valid) begin
                if (req.last) begin
                    item_reg <= '0;
                    nu_reg   <= '0;
                    rep_reg  <= '0;
                    ovf_reg  <= 1'b0;
                end else begin
                    item_reg <= item_next;
                    nu_reg   <= nu_next;
                    rep_reg  <= rep_next;
                    ovf_reg  <= ovf_next;
                end
            end
        end
    end

    // Snapshot of the finished set.
    always_ff @(posedge aclk) begin
        if (req.valid && req.last) begin
            s2_item_reg <= item_next;
            s2_nu_reg   <= nu_next;
            s2_rep_reg  <= rep_next;
            s2_ovf_reg  <= ovf_next;
        end
    end

    // Unique items, clipped to the output field width.
    always_comb begin
        uniq      = (s2_item_reg >= s2_nu_reg) ? (s2_item_reg - s2_nu_reg) : '0;
        uniq_w    = WIDE_BITS'(uniq);
        rep_w     = WIDE_BITS'(s2_rep_reg);
        uniq_over = uniq_w > WIDE_BITS'(OUT_MAX);
        rep_over  = rep_w > WIDE_BITS'(OUT_MAX);

        res.unique_count       = uniq_over ? OUT_MAX : uniq_w[OUT_FIELD_BITS-1:0];
        res.repeated_key_count = rep_over ? OUT_MAX : rep_w[OUT_FIELD_BITS-1:0];
        res.saturated          = s2_ovf_reg | uniq_over | rep_over;
    end

    assign res_valid = s2_valid_reg;

endmodule

// ===== hw/rtl/dic_result_fifo.sv =====
// Small result queue that decouples the counting pipeline from the output.
`timescale 1ns / 1ps

module dic_result_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dic_pkg::result_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output dic_pkg::result_t pop_data
);

    import dic_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    result_t               entries [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  pop;

    assign pop       = pop_valid & pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries[rd_ptr_reg];

    // Storage; upstream credits keep pushes from exceeding the depth.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_BITS'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

endmodule
